// File: rtl/core/rrswc_pkg.sv
package rrswc_pkg;

    localparam int FIELD_BITS = 48;
    localparam int OUT_BITS   = 8;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

endpackage

// File: rtl/core/rrswc_ram.sv
module rrswc_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/read_range_set_write_conflict.sv
// Read range set with write conflict check.
// The slave channel takes one item per access: s_tuser carries the mode (0 records
// a read range, 1 checks a write range), s_tdata the start address and byte count.
// Every item gives exactly one result item on the master channel: bit 0 is the
// write conflict flag, bit 1 the flag for a read dropped on a full table, and
// bits 6:2 the number of entries in use after the item.
// An item with a zero byte count is answered in the cycle after it is accepted.
// Any other item scans the range table in a RAM with one read port, one entry a
// cycle through a single compare and merge unit, then, for a read with a free
// entry, writes the merged range back before the result is offered.
// s_tready is high only while the block is idle, so one item is in work at a time.
// The result stays on m_tdata until m_tready takes it; the next item is accepted
// in the cycle after that.
// A synchronous reset (aresetn low) marks every table entry free, clears the
// entry count and drops any item in work or waiting result.
module read_range_set_write_conflict
    import rrswc_pkg::*;
#(
    parameter int MAX_RANGES = 16,
    parameter int ADDR_BITS  = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*FIELD_BITS-1:0] s_tdata,   // start_address [47:0], byte_count [95:48]
    input  logic [0:0]              s_tuser,   // mode [0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_BITS-1:0]     m_tdata    // conflict [0], table_full [1],
                                               // entries_used [6:2], zero [7]
);

    localparam int AW  = ADDR_BITS;
    localparam int XW  = (AW > FIELD_BITS) ? AW : FIELD_BITS;
    localparam int IW  = $clog2(MAX_RANGES);
    localparam int CW0 = $clog2(MAX_RANGES + 1);
    localparam int CW  = (CW0 > 5) ? CW0 : 5;
    localparam int DW  = 2 * AW + 1;

    state_t              state_reg, state_next;
    logic                mode_reg, mode_next;
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW:0]         hi_reg, hi_next;
    logic [IW:0]         idx_reg, idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IW-1:0]       chk_idx_reg, chk_idx_next;
    logic [MAX_RANGES-1:0] valid_reg, valid_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       new_lo_reg, new_lo_next;
    logic [AW:0]         new_hi_reg, new_hi_next;
    logic                slot_found_reg, slot_found_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic                conflict_reg, conflict_next;
    logic                full_reg, full_next;

    logic [XW-1:0]       in_lo_x, in_size_x;
    logic [AW-1:0]       in_lo, in_size;
    logic [AW:0]         in_hi;
    logic [DW-1:0]       rdata;
    logic [AW-1:0]       ent_start;
    logic [AW:0]         ent_end;
    logic                ent_valid;
    logic                touch, overlap, is_free;
    logic                ram_we;

    assign in_lo_x   = XW'(s_tdata[FIELD_BITS-1:0]);
    assign in_size_x = XW'(s_tdata[2*FIELD_BITS-1:FIELD_BITS]);
    assign in_lo     = in_lo_x[AW-1:0];
    assign in_size   = in_size_x[AW-1:0];
    assign in_hi     = {1'b0, in_lo} + {1'b0, in_size};

    rrswc_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_RANGES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({new_hi_reg, new_lo_reg}),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign ent_start = rdata[AW-1:0];
    assign ent_end   = rdata[DW-1:AW];
    assign ent_valid = valid_reg[chk_idx_reg];
    assign touch     = ({1'b0, ent_start} <= hi_reg) && (ent_end >= {1'b0, lo_reg});
    assign overlap   = ({1'b0, ent_start} < hi_reg) && (ent_end > {1'b0, lo_reg});
    assign is_free   = !ent_valid || ((mode_reg == MODE_READ) && touch);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {1'b0, cnt_reg[4:0], full_reg, conflict_reg};
    assign ram_we   = (state_reg == ST_WRITE) && (mode_reg == MODE_READ) && slot_found_reg;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        new_lo_next     = new_lo_reg;
        new_hi_next     = new_hi_reg;
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        conflict_next   = conflict_reg;
        full_next       = full_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = s_tuser[0];
                    lo_next         = in_lo;
                    hi_next         = in_hi;
                    new_lo_next     = in_lo;
                    new_hi_next     = in_hi;
                    idx_next        = '0;
                    chk_vld_next    = 1'b0;
                    slot_found_next = 1'b0;
                    conflict_next   = 1'b0;
                    full_next       = 1'b0;
                    if (in_size == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg != (IW+1)'(MAX_RANGES)) begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[IW-1:0];
                    idx_next     = idx_reg + (IW+1)'(1);
                end else begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg) begin
                    if (ent_valid) begin
                        if (mode_reg == MODE_WRITE) begin
                            if (overlap) begin
                                conflict_next = 1'b1;
                            end
                        end else if (touch) begin
                            valid_next[chk_idx_reg] = 1'b0;
                            cnt_next = cnt_reg - CW'(1);
                            if (ent_start < new_lo_reg) begin
                                new_lo_next = ent_start;
                            end
                            if (ent_end > new_hi_reg) begin
                                new_hi_next = ent_end;
                            end
                        end
                    end
                    if (is_free && !slot_found_reg) begin
                        slot_found_next = 1'b1;
                        slot_next       = chk_idx_reg;
                    end
                end
                if ((idx_reg == (IW+1)'(MAX_RANGES)) && !chk_vld_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (mode_reg == MODE_READ) begin
                    if (slot_found_reg) begin
                        valid_next[slot_reg] = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end else begin
                        full_next = 1'b1;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        idx_reg        <= idx_next;
        chk_idx_reg    <= chk_idx_next;
        new_lo_reg     <= new_lo_next;
        new_hi_reg     <= new_hi_next;
        slot_found_reg <= slot_found_next;
        slot_reg       <= slot_next;
        conflict_reg   <= conflict_next;
        full_reg       <= full_next;
    end

    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == int'(cnt_reg)))
        else $error("Entry count differs from the number of valid entries.");

    a_full_only_when_all_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && full_reg) |-> (&valid_reg))
        else $error("Read dropped although a free entry exists.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(full_reg && conflict_reg))
        else $error("Conflict and full flags set on the same item.");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("Input accepted while a result is pending.");

    a_ram_write_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(state_reg == ST_SCAN))
        else $error("Table written without a preceding scan.");

endmodule

// File: bench/tb_read_range_set_write_conflict.sv
module tb_read_range_set_write_conflict
    import rrswc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NRANGES       = 16;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = NRANGES + 8;
    localparam logic [47:0] TOP_HALF = 48'h8000_0000_0000;

    typedef struct packed {
        logic       conflict;
        logic       table_full;
        logic [4:0] entries_used;
    } verdict_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [2*FIELD_BITS-1:0] s_tdata  = '0;
    logic [0:0]              s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_BITS-1:0]     m_tdata;

    logic [47:0] span_lo   [NRANGES];
    logic [48:0] span_hi   [NRANGES];
    bit          span_live [NRANGES];

    verdict_t pending[$];
    int       mismatches      = 0;
    int       quiet_cycles    = 0;
    int       hold_off_cycles = 0;
    bit       send_gaps       = 1'b1;
    bit       sink_gaps       = 1'b1;

    read_range_set_write_conflict #(
        .MAX_RANGES(NRANGES),
        .ADDR_BITS (48)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic verdict_t predict_access(logic mode, logic [47:0] addr,
                                                logic [47:0] count);
        verdict_t    v;
        logic [48:0] lo;
        logic [48:0] hi;
        logic [48:0] new_lo;
        logic [48:0] new_hi;
        bit          covered;
        int          slot;
        int          used;
        v = '0;
        lo = {1'b0, addr};
        hi = lo + {1'b0, count};
        if (count != 0) begin
            if (mode == MODE_WRITE) begin
                for (int k = 0; k < NRANGES; k++)
                    if (span_live[k] && {1'b0, span_lo[k]} < hi && span_hi[k] > lo)
                        v.conflict = 1'b1;
            end else begin
                covered = 1'b0;
                for (int k = 0; k < NRANGES; k++)
                    if (span_live[k] && {1'b0, span_lo[k]} <= lo && hi <= span_hi[k])
                        covered = 1'b1;
                if (!covered) begin
                    new_lo = lo;
                    new_hi = hi;
                    // Every entry that overlaps or touches the new range folds into it.
                    for (int k = 0; k < NRANGES; k++) begin
                        if (span_live[k] && {1'b0, span_lo[k]} <= hi && span_hi[k] >= lo) begin
                            if ({1'b0, span_lo[k]} < new_lo) new_lo = {1'b0, span_lo[k]};
                            if (span_hi[k] > new_hi) new_hi = span_hi[k];
                            span_live[k] = 1'b0;
                        end
                    end
                    slot = -1;
                    for (int k = 0; k < NRANGES; k++)
                        if (!span_live[k] && slot < 0) slot = k;
                    if (slot < 0) begin
                        v.table_full = 1'b1;
                    end else begin
                        span_lo[slot]   = new_lo[47:0];
                        span_hi[slot]   = new_hi;
                        span_live[slot] = 1'b1;
                    end
                end
            end
        end
        used = 0;
        for (int k = 0; k < NRANGES; k++)
            if (span_live[k]) used++;
        v.entries_used = used[4:0];
        return v;
    endfunction

    task automatic send_access(input logic mode, input logic [47:0] addr,
                               input logic [47:0] count);
        int gap;
        gap = send_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {count, addr};
        do @(posedge aclk); while (!s_tready);
        pending.push_back(predict_access(mode, addr, count));
    endtask

    task automatic test_zero_size();
        send_access(MODE_READ, 48'h100, 48'h0);
        send_access(MODE_WRITE, 48'h0, 48'h0);
        send_access(MODE_WRITE, 48'h0, '1);
    endtask

    task automatic test_merge_and_touch();
        send_access(MODE_READ, 48'h100, 48'h10);
        send_access(MODE_READ, 48'h110, 48'h10);
        send_access(MODE_READ, 48'h104, 48'h4);
        send_access(MODE_WRITE, 48'h120, 48'h10);
        send_access(MODE_WRITE, 48'h0F0, 48'h10);
        send_access(MODE_WRITE, 48'h11F, 48'h1);
        send_access(MODE_READ, 48'h140, 48'h10);
        send_access(MODE_READ, 48'h120, 48'h20);
    endtask

    task automatic test_wide_addresses();
        send_access(MODE_READ, '1, 48'h1);
        send_access(MODE_READ, '1, '1);
        send_access(MODE_WRITE, '1, '1);
        send_access(MODE_WRITE, 48'h0, '1);
    endtask

    task automatic test_full_table();
        for (int k = 0; k < NRANGES - 2; k++)
            send_access(MODE_READ, 48'h1000 + 48'h40 * 48'(k), 48'h20);
        send_access(MODE_READ, 48'h2000, 48'h8);
        send_access(MODE_READ, 48'h1020, 48'h20);
    endtask

    task automatic test_random_traffic();
        logic [47:0] cursor;
        logic [47:0] addr;
        logic [47:0] count;
        logic        mode;
        int          sent;
        int          win;
        int          pick;
        int          phase_len;
        cursor = 48'h1_0000;
        sent   = 0;
        while (sent < RANDOM_ITEMS) begin
            send_gaps = $urandom_range(0, 4) != 0;
            sink_gaps = $urandom_range(0, 4) != 0;
            // Fold everything below the cursor and everything in the top half into
            // one entry each, so that the next window starts on a nearly empty table.
            send_access(MODE_READ, 48'h0, cursor);
            send_access(MODE_READ, TOP_HALF, '1);
            sent += 2;
            win       = 256 << $urandom_range(0, 4);
            phase_len = $urandom_range(20, 80);
            for (int i = 0; i < phase_len; i++) begin
                pick = $urandom_range(0, 99);
                mode = 1'($urandom_range(0, 1));
                if (pick < 8) begin
                    addr  = (mode == MODE_WRITE) ? rand48() : (TOP_HALF | rand48());
                    count = rand48();
                end else if (pick < 12) begin
                    addr  = rand48();
                    count = 48'h0;
                end else begin
                    mode  = (pick < 60) ? MODE_READ : MODE_WRITE;
                    addr  = cursor + 48'($urandom_range(0, win - 1));
                    count = ($urandom_range(0, 3) == 0) ? 48'($urandom_range(1, win / 4))
                                                        : 48'($urandom_range(1, 48));
                end
                send_access(mode, addr, count);
                sent++;
            end
            cursor = cursor + 48'(2 * win) + 48'($urandom_range(1, 4096));
        end
    endtask

    task automatic test_output_stall();
        send_gaps       = 1'b0;
        hold_off_cycles = 150;
        repeat (8)
            send_access(1'($urandom_range(0, 1)), 48'($urandom_range(0, 'h3000)),
                        48'($urandom_range(0, 64)));
    endtask

    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                gap = sink_gaps ? $urandom_range(0, 8) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                $error("result item with nothing pending: m_tdata=%h", m_tdata);
                mismatches++;
            end else begin
                want = pending.pop_front();
                if (m_tdata[0] !== want.conflict) begin
                    $error("conflict: expected %0d, got %0d", want.conflict, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== want.table_full) begin
                    $error("table_full: expected %0d, got %0d", want.table_full, m_tdata[1]);
                    mismatches++;
                end
                if (m_tdata[6:2] !== want.entries_used) begin
                    $error("entries_used: expected %0d, got %0d", want.entries_used,
                           m_tdata[6:2]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("read_range_set_write_conflict verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < NRANGES; k++) begin
            span_lo[k]   = '0;
            span_hi[k]   = '0;
            span_live[k] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_zero_size();
        test_merge_and_touch();
        test_wide_addresses();
        test_full_table();
        test_random_traffic();
        test_output_stall();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("read_range_set_write_conflict verification clean");
        end else begin
            $display("read_range_set_write_conflict verification failed");
        end
        $finish;
    end

endmodule
